/* rtl/ftws_pkg.sv */
// shared types and constants for the frame-time window statistics block
// no dependencies; used by every module under rtl/ except ftws_divider

package ftws_pkg;

    // field widths
    localparam int FRAME_W  = 24;
    localparam int COUNT_W  = 7;
    localparam int BUDGET_W = 17;

    // default window length
    localparam int WINDOW_DEFAULT = 120;

    // fps in tenths: ten million over the mean frame time
    localparam int FPS_NUMERATOR = 10000000;

    // budget percent = sample * 6 / 1000, division by reciprocal multiply
    localparam int BUDGET_MUL     = 6;
    localparam int BUDGET_DIV     = 1000;
    localparam int BUDGET_X_W     = FRAME_W + 3;
    localparam int BUDGET_SHIFT   = 32;
    localparam longint BUDGET_RECIP = (64'd1 << BUDGET_SHIFT) / BUDGET_DIV;
    localparam int BUDGET_RECIP_W = 23;
    localparam int BUDGET_PROD_W  = BUDGET_X_W + BUDGET_RECIP_W;
    localparam int BUDGET_Q_W     = BUDGET_PROD_W - BUDGET_SHIFT;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // operation carried in tuser
    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_CLEAR = 1'b1
    } kind_t;

    // one queued item
    typedef struct packed {
        kind_t              kind;
        logic [FRAME_W-1:0] frame_time_us;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // one result item
    typedef struct packed {
        logic [BUDGET_W-1:0] budget_percent;
        logic [FRAME_W-1:0]  fps_tenths;
        logic [COUNT_W-1:0]  sample_count;
        logic [FRAME_W-1:0]  max_us;
        logic [FRAME_W-1:0]  min_us;
        logic [FRAME_W-1:0]  mean_us;
    } result_t;

endpackage

/* rtl/ftws_front.sv */
// front end: accepts input items, decodes the operation, queues them
// depends on ftws_pkg

module ftws_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_op,
    input  logic [ftws_pkg::FRAME_W-1:0] in_time,
    output ftws_pkg::q_head_t            head,
    input  logic                         pop
);

    localparam int PTR_W = (ftws_pkg::QUEUE_DEPTH > 1) ? $clog2(ftws_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ftws_pkg::QUEUE_DEPTH + 1);

    ftws_pkg::item_t  slot_reg [ftws_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    ftws_pkg::item_t  in_item;
    logic             push;
    logic             do_pop;

    // classify the incoming item
    always_comb begin
        in_item.kind          = in_op ? ftws_pkg::KIND_CLEAR : ftws_pkg::KIND_ADD;
        in_item.frame_time_us = in_time;
    end

    assign in_ready = (cnt_reg != CNT_W'(ftws_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (cnt_reg != '0);
    assign head     = {(cnt_reg != '0), slot_reg[rd_ptr_reg]};

    // queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ftws_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ftws_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/ftws_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on nothing beyond its parameter

module ftws_divider #(
    parameter int DW = 31
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int STEP_W = $clog2(DW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     quo_reg;
    logic [DW-1:0]     dsr_reg;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;

    // trial subtraction for the current bit
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/ftws_engine.sv */
// back end: sample ring, running sum, min/max walk, divisions, result register
// depends on ftws_pkg and ftws_divider

module ftws_engine #(
    parameter int WINDOW = ftws_pkg::WINDOW_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ftws_pkg::q_head_t   head,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output ftws_pkg::result_t   res
);

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = ftws_pkg::FRAME_W + $clog2(WINDOW);
    localparam int FW = ftws_pkg::FRAME_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_UPDATE,
        S_BUD_MUL,
        S_BUD_EST,
        S_BUD_FIX,
        S_WALK,
        S_DIV_MEAN,
        S_WAIT_MEAN,
        S_DIV_FPS,
        S_WAIT_FPS,
        S_OUT
    } state_t;

    state_t  state_reg;

    // ring memory
    logic [FW-1:0] ring [WINDOW];
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] rd_data_reg;
    logic          wr_en;

    // window state
    logic [AW-1:0] write_slot_reg;
    logic [CW-1:0] held_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic          full;

    // per item work registers
    logic [FW-1:0] sample_reg;
    logic [CW-1:0] issue_reg;
    logic          pend_reg;
    logic          first_reg;
    logic [FW-1:0] lo_reg;
    logic [FW-1:0] hi_reg;
    logic [FW-1:0] mean_reg;
    logic [FW-1:0] fps_reg;
    logic [ftws_pkg::BUDGET_PROD_W-1:0] bud_prod_reg;
    logic [ftws_pkg::BUDGET_Q_W-1:0]    bud_q_reg;
    logic [ftws_pkg::BUDGET_W-1:0]      budget_reg;
    logic [ftws_pkg::BUDGET_X_W-1:0]    bud_x;
    logic [ftws_pkg::BUDGET_X_W-1:0]    bud_rem;

    // result register
    logic              res_valid_reg;
    ftws_pkg::result_t res_reg;

    // divider hookup
    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [SW-1:0] div_divisor;
    logic          div_done;
    logic [SW-1:0] div_quotient;

    ftws_divider #(
        .DW (SW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // divider operand select
    always_comb begin
        div_start    = (state_reg == S_DIV_MEAN) || (state_reg == S_DIV_FPS);
        div_dividend = sum_reg;
        div_divisor  = SW'(held_reg);
        if (state_reg == S_DIV_FPS) begin
            div_dividend = SW'(ftws_pkg::FPS_NUMERATOR);
            div_divisor  = SW'(mean_reg);
        end
    end

    // sample times six by shift and add, remainder check for the budget
    assign bud_x   = {sample_reg, 2'b00} + {1'b0, sample_reg, 1'b0};
    assign bud_rem = bud_x - ftws_pkg::BUDGET_X_W'(bud_q_reg * ftws_pkg::BUDGET_DIV);

    // window update values
    assign full     = (held_reg == CW'(WINDOW));
    assign sum_next = sum_reg - (full ? SW'(rd_data_reg) : '0) + SW'(sample_reg);

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = write_slot_reg;
        wr_en   = (state_reg == S_UPDATE);
        if (state_reg == S_RD_OLD) begin
            rd_en = 1'b1;
        end else if (state_reg == S_WALK) begin
            rd_en   = (issue_reg < held_reg);
            rd_addr = issue_reg[AW-1:0];
        end
    end

    // ring storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[write_slot_reg] <= sample_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring[rd_addr];
        end
    end

    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // sequencer with control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            write_slot_reg <= '0;
            held_reg       <= '0;
            sum_reg        <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            first_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            // result taken; in S_OUT the reload below decides instead
            if (res_valid_reg && res_ready && (state_reg != S_OUT)) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (head.valid) begin
                        if (head.item.kind == ftws_pkg::KIND_CLEAR) begin
                            write_slot_reg <= '0;
                            held_reg       <= '0;
                            sum_reg        <= '0;
                        end else begin
                            sample_reg <= head.item.frame_time_us;
                            state_reg  <= S_RD_OLD;
                        end
                    end
                end
                S_RD_OLD: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    sum_reg <= sum_next;
                    if (!full) begin
                        held_reg <= held_reg + 1'b1;
                    end
                    write_slot_reg <= (write_slot_reg == AW'(WINDOW - 1))
                                      ? '0 : write_slot_reg + 1'b1;
                    state_reg <= S_BUD_MUL;
                end
                S_BUD_MUL: begin
                    bud_prod_reg <= ftws_pkg::BUDGET_PROD_W'(bud_x
                                    * ftws_pkg::BUDGET_RECIP_W'(ftws_pkg::BUDGET_RECIP));
                    state_reg    <= S_BUD_EST;
                end
                S_BUD_EST: begin
                    bud_q_reg <= bud_prod_reg[ftws_pkg::BUDGET_PROD_W-1:ftws_pkg::BUDGET_SHIFT];
                    state_reg <= S_BUD_FIX;
                end
                S_BUD_FIX: begin
                    // estimate is low by at most one
                    if (bud_rem >= ftws_pkg::BUDGET_X_W'(ftws_pkg::BUDGET_DIV)) begin
                        budget_reg <= ftws_pkg::BUDGET_W'(bud_q_reg + 1'b1);
                    end else begin
                        budget_reg <= ftws_pkg::BUDGET_W'(bud_q_reg);
                    end
                    issue_reg <= '0;
                    pend_reg  <= 1'b0;
                    first_reg <= 1'b1;
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    // issue one read per cycle, fold the one returned
                    if (issue_reg < held_reg) begin
                        issue_reg <= issue_reg + 1'b1;
                        pend_reg  <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        first_reg <= 1'b0;
                        if (first_reg || (rd_data_reg < lo_reg)) begin
                            lo_reg <= rd_data_reg;
                        end
                        if (first_reg || (rd_data_reg > hi_reg)) begin
                            hi_reg <= rd_data_reg;
                        end
                    end
                    if ((issue_reg >= held_reg) && !pend_reg) begin
                        state_reg <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN: begin
                    state_reg <= S_WAIT_MEAN;
                end
                S_WAIT_MEAN: begin
                    if (div_done) begin
                        mean_reg <= div_quotient[FW-1:0];
                        if (div_quotient[FW-1:0] == '0) begin
                            fps_reg   <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_DIV_FPS;
                        end
                    end
                end
                S_DIV_FPS: begin
                    state_reg <= S_WAIT_FPS;
                end
                S_WAIT_FPS: begin
                    if (div_done) begin
                        fps_reg   <= div_quotient[FW-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load the result once the previous one has gone
                    if (!res_valid_reg || res_ready) begin
                        res_reg.mean_us        <= mean_reg;
                        res_reg.min_us         <= lo_reg;
                        res_reg.max_us         <= hi_reg;
                        res_reg.sample_count   <= ftws_pkg::COUNT_W'(held_reg);
                        res_reg.fps_tenths     <= fps_reg;
                        res_reg.budget_percent <= budget_reg;
                        res_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/frame_time_window_stats_top.sv */
// An add passes the queue, the ring read and update, the budget steps, the ring walk, the mean
// division and the fps division before the result register; a zero mean skips the second division.
// Throughput: the back end works on one sample at a time, paced by the one-port ring walk and
// the shared serial divider, and a result still waiting for its handshake holds the back end;
// a clear is handled in the idle state without the walk or the divisions.
// Reset: synchronous aresetn clears count, slot, sum, queue and handshakes, not the ring.

module frame_time_window_stats_top #(
    parameter int WINDOW = ftws_pkg::WINDOW_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // frame_time_us[23:0]
    input  logic [0:0]   s_axis_tuser,   // op[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata    // mean_us, min_us, max_us, sample_count,
                                         // fps_tenths, budget_percent
);

    ftws_pkg::q_head_t head;
    logic              pop;
    ftws_pkg::result_t res;

    // front: accept and classify
    ftws_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser[0]),
        .in_time  (s_axis_tdata),
        .head     (head),
        .pop      (pop)
    );

    // back: window statistics
    ftws_engine #(
        .WINDOW (WINDOW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result item, first field lowest
    assign m_axis_tdata = {res.budget_percent, res.fps_tenths, res.sample_count,
                           res.max_us, res.min_us, res.mean_us};

endmodule
